// ===== sv/frfls_pkg.sv =====
`timescale 1ns / 1ps

package frfls_pkg;

   localparam int SLOTS  = 256;
   localparam int SLOT_W = $clog2(SLOTS + 1);
   localparam int IDX_W  = $clog2(SLOTS);

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_RANGE   = 2'd2;
   localparam logic [1:0] ST_DELETED = 2'd3;

   typedef struct packed {
      logic [1:0]        kind;
      logic [SLOT_W-1:0] slot;
      logic [31:0]       student_code;
      logic [7:0]        term;
      logic [31:0]       fee_bits;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot_used;
      logic              live;
      logic [31:0]       code_out;
      logic [7:0]        term_out;
      logic [31:0]       fee_out;
   } rsp_type;

   typedef struct packed {
      logic        live;
      logic [31:0] code;
      logic [7:0]  term;
      logic [31:0] fee;
   } rec_type;

   typedef struct packed {
      logic accept;
      logic commit;
   } cmd_type;

endpackage

// ===== sv/frfls_ctl.sv =====
`timescale 1ns / 1ps

module frfls_ctl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output frfls_pkg::cmd_type  cmd
);

   typedef enum logic {
      IDLE,
      EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_busy;

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;
   // the output register frees up in the same cycle it is taken
   assign out_busy  = rsp_valid_ff && !rsp_ready;

   always_comb begin
      cmd.accept   = req_valid && (state_ff == IDLE);
      cmd.commit   = (state_ff == EXEC) && !out_busy;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         IDLE: begin
            if (cmd.accept) begin
               state_in = EXEC;
            end
         end
         EXEC: begin
            if (cmd.commit) begin
               state_in     = IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == EXEC) && !req_ready)
      else $error("accepted item did not move to execute");

   a_commit_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (state_ff == IDLE) && rsp_valid_ff)
      else $error("commit did not present a result");

   a_commit_only_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && !rsp_ready))
      else $error("commit overwrote a pending result");

endmodule

// ===== sv/frfls_dp.sv =====
`timescale 1ns / 1ps

module frfls_dp (
   input  logic               clock,
   input  logic               reset,
   input  frfls_pkg::cmd_type cmd,
   input  frfls_pkg::req_type req_data,
   output frfls_pkg::rsp_type rsp_data
);

   localparam logic [frfls_pkg::SLOT_W-1:0] SLOT_ONE = frfls_pkg::SLOT_W'(1);
   localparam logic [frfls_pkg::SLOT_W-1:0] SLOT_MAX =
      frfls_pkg::SLOT_W'(frfls_pkg::SLOTS);

   frfls_pkg::rec_type rec_mem [frfls_pkg::SLOTS];
   logic [frfls_pkg::SLOT_W-1:0] next_mem [frfls_pkg::SLOTS];

   frfls_pkg::req_type            item_ff;
   frfls_pkg::rec_type            rd_rec_ff;
   logic [frfls_pkg::SLOT_W-1:0]  rd_next_ff;
   logic [frfls_pkg::SLOT_W-1:0]  free_head_ff, free_head_in;
   logic [frfls_pkg::SLOT_W-1:0]  used_count_ff, used_count_in;
   frfls_pkg::rsp_type            rsp_ff, rsp_in;

   logic [frfls_pkg::SLOT_W-1:0]  rd_slot, head_less, slot_less, target, used_inc;
   logic [frfls_pkg::IDX_W-1:0]   rd_addr, wr_addr;
   logic                          rec_we, next_we;
   frfls_pkg::rec_type            wr_rec;
   logic                          head_ok, range_bad;

   // add reads the link of the current head, delete and read read their slot
   assign rd_slot   = (req_data.kind == frfls_pkg::KIND_ADD) ? free_head_ff : req_data.slot;
   assign head_less = rd_slot - SLOT_ONE;
   assign rd_addr   = head_less[frfls_pkg::IDX_W-1:0];
   assign rsp_data  = rsp_ff;

   always_comb begin
      free_head_in  = free_head_ff;
      used_count_in = used_count_ff;
      rsp_in        = '0;
      rec_we        = 1'b0;
      next_we       = 1'b0;
      wr_rec        = rd_rec_ff;
      target        = item_ff.slot;
      head_ok       = (free_head_ff != '0) && (free_head_ff <= used_count_ff);
      range_bad     = (item_ff.slot == '0) || (item_ff.slot > used_count_ff);
      used_inc      = used_count_ff + SLOT_ONE;

      unique case (item_ff.kind)
         frfls_pkg::KIND_ADD: begin
            wr_rec.live = 1'b1;
            wr_rec.code = item_ff.student_code;
            wr_rec.term = item_ff.term;
            wr_rec.fee  = item_ff.fee_bits;
            if (head_ok) begin
               target       = free_head_ff;
               free_head_in = rd_next_ff;
               rec_we       = 1'b1;
            end else if (used_count_ff < SLOT_MAX) begin
               target        = used_inc;
               used_count_in = used_inc;
               rec_we        = 1'b1;
            end
            if (rec_we) begin
               rsp_in.status    = frfls_pkg::ST_OK;
               rsp_in.slot_used = target;
               rsp_in.live      = 1'b1;
            end else begin
               rsp_in.status = frfls_pkg::ST_FULL;
            end
         end
         frfls_pkg::KIND_DELETE: begin
            if (range_bad) begin
               rsp_in.status = frfls_pkg::ST_RANGE;
            end else if (!rd_rec_ff.live) begin
               rsp_in.status = frfls_pkg::ST_DELETED;
            end else begin
               wr_rec.live      = 1'b0;
               rec_we           = 1'b1;
               next_we          = 1'b1;
               free_head_in     = item_ff.slot;
               rsp_in.status    = frfls_pkg::ST_OK;
               rsp_in.slot_used = item_ff.slot;
            end
         end
         frfls_pkg::KIND_READ: begin
            if (range_bad) begin
               rsp_in.status = frfls_pkg::ST_RANGE;
            end else begin
               rsp_in.status    = frfls_pkg::ST_OK;
               rsp_in.slot_used = item_ff.slot;
               rsp_in.live      = rd_rec_ff.live;
               rsp_in.code_out  = rd_rec_ff.code;
               rsp_in.term_out  = rd_rec_ff.term;
               rsp_in.fee_out   = rd_rec_ff.fee;
            end
         end
         default: begin
            rsp_in.status = frfls_pkg::ST_RANGE;
         end
      endcase

      slot_less = target - SLOT_ONE;
      wr_addr   = slot_less[frfls_pkg::IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff    <= req_data;
         rd_rec_ff  <= rec_mem[rd_addr];
         rd_next_ff <= next_mem[rd_addr];
      end
      if (cmd.commit && rec_we) begin
         rec_mem[wr_addr] <= wr_rec;
      end
      if (cmd.commit && next_we) begin
         next_mem[wr_addr] <= free_head_ff;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff  <= '0;
         used_count_ff <= '0;
      end else if (cmd.commit) begin
         free_head_ff  <= free_head_in;
         used_count_ff <= used_count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      used_count_ff <= SLOT_MAX)
      else $error("slot count beyond store size");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      free_head_ff <= used_count_ff)
      else $error("free list head beyond handed-out slots");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> $stable(free_head_ff) && $stable(used_count_ff))
      else $error("list state changed without a commit");

endmodule

// ===== sv/fixed_record_free_list_store.sv =====
`timescale 1ns / 1ps

// Record store with a last-in first-out free list threaded through deleted
// slots. Slots are numbered from 1.
// Request channel (req_valid/req_ready/req_data): kind add, delete or read,
// a slot for delete and read, and the record fields stored by add.
// Response channel (rsp_valid/rsp_ready/rsp_data): one item per request with
// status, slot used, live flag and, for reads, the stored record.
// Each request reads then writes: the accept edge reads the record and link
// memories (the head slot for add, the given slot otherwise), and the commit
// edge writes back and loads the response register. A new request is not
// accepted until the previous one commits, set by this read-then-write on
// single-port memories. rsp_valid rises at the commit edge, which follows the
// accept edge unless a waiting response holds the item in execute.
// A waiting response does not block the next accept; that item holds in its
// execute cycle until the response register is taken.
// Reset empties the free list and the slot count; the memories are not
// cleared, and only records of slots already handed out are ever used.
module fixed_record_free_list_store (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  frfls_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output frfls_pkg::rsp_type rsp_data
);

   frfls_pkg::cmd_type cmd;

   frfls_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   frfls_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ===== test/record_store_checker.sv =====
`timescale 1ns / 1ps

module record_store_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  frfls_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  frfls_pkg::rsp_type rsp_data,
   output int                 mismatch_total,
   output int                 awaited
);

   // shadow of the store: free-list head, slots handed out, per-slot link and record
   logic [frfls_pkg::SLOT_W-1:0] head_slot;
   logic [frfls_pkg::SLOT_W-1:0] slots_taken;
   logic [frfls_pkg::SLOT_W-1:0] link_mem [1:frfls_pkg::SLOTS];
   logic                         live_mem [1:frfls_pkg::SLOTS];
   logic [31:0]                  code_mem [1:frfls_pkg::SLOTS];
   logic [7:0]                   term_mem [1:frfls_pkg::SLOTS];
   logic [31:0]                  fee_mem  [1:frfls_pkg::SLOTS];

   frfls_pkg::rsp_type expected_rsps [$];
   frfls_pkg::rsp_type want;
   int                 fail_tally = 0;
   logic               bad;

   function automatic frfls_pkg::rsp_type execute_request(input frfls_pkg::req_type r);
      frfls_pkg::rsp_type           res;
      logic [frfls_pkg::SLOT_W-1:0] target;
      res = '0;
      target = '0;
      case (r.kind)
         frfls_pkg::KIND_ADD: begin
            // pop the free list first, else append a fresh slot
            if (head_slot != '0) begin
               target = head_slot;
               head_slot = link_mem[target];
            end else if (slots_taken < frfls_pkg::SLOTS) begin
               slots_taken = slots_taken + 1'b1;
               target = slots_taken;
            end
            if (target == '0) begin
               res.status = frfls_pkg::ST_FULL;
            end else begin
               live_mem[target] = 1'b1;
               code_mem[target] = r.student_code;
               term_mem[target] = r.term;
               fee_mem[target]  = r.fee_bits;
               res.status    = frfls_pkg::ST_OK;
               res.slot_used = target;
               res.live      = 1'b1;
            end
         end
         frfls_pkg::KIND_DELETE, frfls_pkg::KIND_READ: begin
            if (r.slot == '0 || r.slot > slots_taken) begin
               res.status = frfls_pkg::ST_RANGE;
            end else if (r.kind == frfls_pkg::KIND_DELETE) begin
               if (!live_mem[r.slot]) begin
                  res.status = frfls_pkg::ST_DELETED;
               end else begin
                  live_mem[r.slot] = 1'b0;
                  link_mem[r.slot] = head_slot;
                  head_slot = r.slot;
                  res.status    = frfls_pkg::ST_OK;
                  res.slot_used = r.slot;
               end
            end else begin
               res.status    = frfls_pkg::ST_OK;
               res.slot_used = r.slot;
               res.live      = live_mem[r.slot];
               res.code_out  = code_mem[r.slot];
               res.term_out  = term_mem[r.slot];
               res.fee_out   = fee_mem[r.slot];
            end
         end
         default: begin
            res.status = frfls_pkg::ST_RANGE;
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         head_slot = '0;
         slots_taken = '0;
         expected_rsps.delete();
      end else begin
         // retire the response before queuing this edge's request
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               fail_tally++;
               if (fail_tally <= 10) begin
                  $display("%0t: response with none expected: status %0d slot %0d",
                           $time, rsp_data.status, rsp_data.slot_used);
               end
            end else begin
               want = expected_rsps.pop_front();
               bad = (rsp_data.status !== want.status)
                  || (rsp_data.slot_used !== want.slot_used)
                  || (rsp_data.live !== want.live)
                  || (rsp_data.code_out !== want.code_out)
                  || (rsp_data.term_out !== want.term_out)
                  || (rsp_data.fee_out !== want.fee_out);
               if (bad) begin
                  fail_tally++;
                  if (fail_tally <= 10) begin
                     $display("%0t: expected status %0d slot %0d live %0b code %h term %h fee %h",
                              $time, want.status, want.slot_used, want.live,
                              want.code_out, want.term_out, want.fee_out);
                     $display("%0t:      got status %0d slot %0d live %0b code %h term %h fee %h",
                              $time, rsp_data.status, rsp_data.slot_used, rsp_data.live,
                              rsp_data.code_out, rsp_data.term_out, rsp_data.fee_out);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_rsps.insert(expected_rsps.size(), execute_request(req_data));
         end
      end
      mismatch_total <= fail_tally;
      awaited <= expected_rsps.size();
   end

endmodule

// ===== test/fixed_record_free_list_store_tb.sv =====
`timescale 1ns / 1ps

module fixed_record_free_list_store_tb;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int PHASE_ITEMS = 440;
   localparam int SEGMENT     = 160;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   frfls_pkg::req_type req_data  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   frfls_pkg::rsp_type rsp_data;

   int mismatch_total;
   int awaited;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int adds_sent     = 0;

   fixed_record_free_list_store u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   record_store_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_total (mismatch_total),
      .awaited        (awaited)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic frfls_pkg::req_type make_req(input logic [1:0] kind, input int slot,
                                                   input logic [31:0] code,
                                                   input logic [7:0] term,
                                                   input logic [31:0] fee);
      frfls_pkg::req_type r;
      r.kind         = kind;
      r.slot         = frfls_pkg::SLOT_W'(slot);
      r.student_code = code;
      r.term         = term;
      r.fee_bits     = fee;
      return r;
   endfunction

   // drop valid for random gaps, then hold the item until it is taken
   task automatic send_request(input frfls_pkg::req_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // fill segments mostly add, drain segments mostly delete
   task automatic send_random(input bit filling);
      int         pick;
      int         hi;
      int         slot;
      logic [1:0] kind;
      pick = $urandom_range(99);
      if (pick < 2) kind = KIND_UNUSED;
      else if (pick < (filling ? 87 : 17)) kind = frfls_pkg::KIND_ADD;
      else if (pick < (filling ? 90 : 72)) kind = frfls_pkg::KIND_DELETE;
      else kind = frfls_pkg::KIND_READ;
      hi = (adds_sent < frfls_pkg::SLOTS) ? adds_sent : frfls_pkg::SLOTS;
      if ($urandom_range(99) < 85 && hi > 0) slot = $urandom_range(hi, 1);
      else slot = $urandom_range(511, 0);
      if (kind == frfls_pkg::KIND_ADD) adds_sent++;
      send_request(make_req(kind, slot, $urandom, 8'($urandom_range(255, 0)), $urandom));
   endtask

   initial begin
      int n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_request(make_req(frfls_pkg::KIND_READ, 1, '0, '0, '0));
      send_request(make_req(frfls_pkg::KIND_DELETE, 1, '0, '0, '0));
      send_request(make_req(frfls_pkg::KIND_ADD, 0, 32'h0, 8'h00, 32'h0));
      send_request(make_req(frfls_pkg::KIND_ADD, 511, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
      send_request(make_req(frfls_pkg::KIND_READ, 1, '0, '0, '0));
      send_request(make_req(frfls_pkg::KIND_READ, 2, '0, '0, '0));
      send_request(make_req(frfls_pkg::KIND_DELETE, 2, '0, '0, '0));
      send_request(make_req(frfls_pkg::KIND_DELETE, 2, '0, '0, '0));
      send_request(make_req(frfls_pkg::KIND_READ, 2, '0, '0, '0));
      send_request(make_req(frfls_pkg::KIND_DELETE, 0, '0, '0, '0));
      send_request(make_req(frfls_pkg::KIND_READ, 0, '0, '0, '0));
      send_request(make_req(frfls_pkg::KIND_READ, 511, '0, '0, '0));
      send_request(make_req(frfls_pkg::KIND_DELETE, 3, '0, '0, '0));
      send_request(make_req(KIND_UNUSED, 1, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
      send_request(make_req(frfls_pkg::KIND_ADD, 0, 32'h4142_4344, 8'h01, 32'h3F80_0000));
      send_request(make_req(frfls_pkg::KIND_DELETE, 1, '0, '0, '0));
      send_request(make_req(frfls_pkg::KIND_DELETE, 2, '0, '0, '0));
      send_request(make_req(frfls_pkg::KIND_ADD, 0, 32'h5A5A_A5A5, 8'h80, 32'h8000_0001));
      send_request(make_req(frfls_pkg::KIND_ADD, 0, 32'h1234_5678, 8'h7F, 32'h7F7F_FFFF));
      send_request(make_req(frfls_pkg::KIND_ADD, 0, 32'hDEAD_BEEF, 8'h55, 32'h0000_0001));
      send_request(make_req(frfls_pkg::KIND_READ, 1, '0, '0, '0));
      send_request(make_req(frfls_pkg::KIND_READ, 3, '0, '0, '0));
      send_request(make_req(frfls_pkg::KIND_READ, 256, '0, '0, '0));
      adds_sent = 6;

      n = 0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin req_idle_pct = 0;  rsp_stall_pct <= 0;  end
            1: begin req_idle_pct = 87; rsp_stall_pct <= 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct <= 87; end
            default: begin req_idle_pct = 8; rsp_stall_pct <= 8; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_random(((n / SEGMENT) % 2) == 0);
            n++;
         end
      end

      req_valid <= 1'b0;
      rsp_stall_pct <= 0;
      repeat (2) @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_total == 0 && awaited == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
sv/frfls_pkg.sv
sv/frfls_ctl.sv
sv/frfls_dp.sv
sv/fixed_record_free_list_store.sv
test/record_store_checker.sv
test/fixed_record_free_list_store_tb.sv
